### hdl/lateral_track_bank_control_core_assert.svh
// Assertion macros shared by the checker file.
`ifndef LATERAL_TRACK_BANK_CONTROL_CORE_ASSERT_SVH
`define LATERAL_TRACK_BANK_CONTROL_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LTBC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LTBC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### hdl/ltbc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ltbc_pkg
// Constants and the CORDIC arctangent table of the lateral track controller.
// ---------------------------------------------------------------------------
package ltbc_pkg;

    localparam logic [1:0] REG_BANK_LIMIT = 2'd0;
    localparam logic [1:0] REG_LA_GAIN    = 2'd1;
    localparam logic [1:0] REG_TR_GAIN    = 2'd2;
    localparam logic [1:0] REG_ENABLE     = 2'd3;

    localparam logic [13:0] BANK_LIMIT_RST = 14'd8579;
    localparam logic [31:0] LA_GAIN_RST    = 32'd2963192;
    localparam logic [31:0] TR_GAIN_RST    = 32'd83886;

    // Gravity, 9.80665 m/s^2 in Q.24.
    localparam logic signed [49:0] GRAV_Q24 = 50'sd164528285;

    localparam int TABLE_LEN = 32;

    // atan(2^-i) in unsigned Q0.30.
    function automatic logic [29:0] atan_q30(input logic [4:0] idx);
        logic [29:0] v;
        unique case (idx)
            5'd0:  v = 30'd843314857;
            5'd1:  v = 30'd497837829;
            5'd2:  v = 30'd263043837;
            5'd3:  v = 30'd133525159;
            5'd4:  v = 30'd67021687;
            5'd5:  v = 30'd33543516;
            5'd6:  v = 30'd16775851;
            5'd7:  v = 30'd8388437;
            5'd8:  v = 30'd4194283;
            5'd9:  v = 30'd2097149;
            5'd31: v = 30'd0;
            default: v = 30'd1 << (5'd30 - idx);
        endcase
        return v;
    endfunction

endpackage

### hdl/lateral_track_bank_control_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lateral_track_bank_control_core
// Look-ahead lateral track law: bank command from track-frame velocity and
// cross-track position, via bit-serial products and an iterative CORDIC.
// ---------------------------------------------------------------------------
//  Channel  Signals                                 Direction
//  in       i_in_valid / o_in_ready + input fields  into block
//  out      o_out_valid / i_out_ready + results     out of block
//  cfg      i_cfg_we, i_cfg_index, i_cfg_data       into block, write only
//
// An airspeed update is taken in S_IDLE and leaves the core ready. A tracking
// step runs a check in S_CHK, then six shift-add products, each one multiplier
// bit per cycle up to its highest set bit plus a hand-over step, then the
// CORDIC_STEPS iterations (capped at 32), a round and clamp, and the load of
// the output register in S_OUT; a heading-away step goes from the check straight
// to the output register; disabled or with airspeed not above zero, a step ends at
// the check. Reset is synchronous and active low. A finished word waits in the
// output register while a new word is taken; the core stalls only if that
// register is still full when its next result is ready.
module lateral_track_bank_control_core #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_command,
    input  logic [15:0] i_airspeed,
    input  logic [15:0] i_track_vel_x,
    input  logic [15:0] i_track_vel_y,
    input  logic [23:0] i_cross_track_pos,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [14:0] o_bank_command,
    output logic        o_reversed,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import ltbc_pkg::*;

    localparam int LP_STEPS = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;

    typedef enum logic [2:0] {S_IDLE, S_CHK, S_MUL, S_CORD, S_OUT} t_state;
    typedef enum logic [2:0] {P_VSQ, P_XLA, P_P1, P_P2, P_R, P_RV} t_phase;

    t_state r_state;
    t_phase r_phase;

    logic [13:0] r_bank_limit;
    logic [31:0] r_la_gain;
    logic [31:0] r_tr_gain;
    logic        r_enable;
    logic [15:0] r_airspeed;

    logic [15:0] r_vx;
    logic [15:0] r_vy;
    logic [23:0] r_yp;

    logic [79:0] r_ma;
    logic [31:0] r_mb;
    logic [79:0] r_acc;
    logic [47:0] r_p1;
    logic        r_neg;

    logic signed [49:0] r_cx;
    logic signed [49:0] r_cy;
    logic signed [33:0] r_cz;
    logic [5:0]         r_i;

    logic [14:0] r_res_bank;
    logic        r_res_rev;
    logic        r_out_valid;
    logic [14:0] r_out_bank;
    logic        r_out_rev;

    logic signed [47:0] n_s1;
    logic signed [47:0] n_s2;
    logic signed [47:0] n_sum;
    logic [47:0]        n_mag;
    logic [31:0]        n_r;
    logic signed [49:0] n_dx;
    logic signed [49:0] n_dy;
    logic signed [33:0] n_zs;
    logic signed [17:0] n_rnd;
    logic signed [17:0] n_bank;
    logic signed [17:0] n_mb;
    logic [16:0]        n_avy;
    logic signed [17:0] n_nvx;
    logic               n_away;

    always_comb begin
        n_s1  = r_vy[15] ? -$signed(r_p1) : $signed(r_p1);
        n_s2  = (r_yp[23] ^ r_vx[15]) ? -$signed(r_acc[47:0]) : $signed(r_acc[47:0]);
        n_sum = n_s1 + n_s2;
        n_mag = n_sum[47] ? 48'(-n_sum) : 48'(n_sum);
        n_r   = (|r_acc[79:56]) ? 32'hFFFF_FFFF : r_acc[55:24];

        n_dx  = r_cy >>> r_i[4:0];
        n_dy  = r_cx >>> r_i[4:0];

        n_zs   = r_cz + 34'sd32768;
        n_rnd  = n_zs[33:16];
        n_mb   = $signed({4'd0, r_bank_limit});
        n_bank = r_neg ? -n_rnd : n_rnd;
        if (n_bank > n_mb) begin
            n_bank = n_mb;
        end else if (n_bank < -n_mb) begin
            n_bank = -n_mb;
        end

        n_avy  = r_vy[15] ? 17'(-$signed({1'b1, r_vy})) : {1'b0, r_vy};
        n_nvx  = -$signed({{2{r_vx[15]}}, r_vx});
        n_away = $signed({1'b0, n_avy}) <= n_nvx;
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_bank_command = r_out_bank;
    assign o_reversed     = r_out_rev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_phase      <= P_VSQ;
            r_bank_limit <= BANK_LIMIT_RST;
            r_la_gain    <= LA_GAIN_RST;
            r_tr_gain    <= TR_GAIN_RST;
            r_enable     <= 1'b0;
            r_airspeed   <= 16'd0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_BANK_LIMIT: r_bank_limit <= i_cfg_data[13:0];
                    REG_LA_GAIN:    r_la_gain    <= i_cfg_data;
                    REG_TR_GAIN:    r_tr_gain    <= i_cfg_data;
                    REG_ENABLE:     r_enable     <= i_cfg_data[0];
                endcase
            end

            // The output stage reloads the register itself in S_OUT.
            if (r_out_valid && i_out_ready && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        if (!i_command) begin
                            r_airspeed <= i_airspeed;
                        end else begin
                            r_vx    <= i_track_vel_x;
                            r_vy    <= i_track_vel_y;
                            r_yp    <= i_cross_track_pos;
                            r_state <= S_CHK;
                        end
                    end
                end
                S_CHK: begin
                    if (!r_enable || r_airspeed[15] || r_airspeed == 16'd0) begin
                        r_state <= S_IDLE;
                    end else if (n_away) begin
                        r_res_bank <= r_vy[15] ? {1'b0, r_bank_limit}
                                               : 15'(-$signed({1'b0, r_bank_limit}));
                        r_res_rev  <= 1'b1;
                        r_state    <= S_OUT;
                    end else begin
                        r_phase <= P_VSQ;
                        r_ma    <= {64'd0, r_airspeed};
                        r_mb    <= {16'd0, r_airspeed};
                        r_acc   <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (r_mb != 32'd0) begin
                        // One multiplier bit per cycle.
                        if (r_mb[0]) begin
                            r_acc <= r_acc + r_ma;
                        end
                        r_ma <= {r_ma[78:0], 1'b0};
                        r_mb <= {1'b0, r_mb[31:1]};
                    end else begin
                        r_acc <= '0;
                        unique case (r_phase)
                            P_VSQ: begin
                                r_ma    <= {50'd0, r_acc[29:0]};
                                r_mb    <= r_la_gain;
                                r_phase <= P_XLA;
                            end
                            P_XLA: begin
                                r_ma    <= {50'd0, r_acc[61:32]};
                                r_mb    <= {15'd0, n_avy};
                                r_phase <= P_P1;
                            end
                            P_P1: begin
                                r_p1    <= r_acc[47:0];
                                r_ma    <= {56'd0, r_yp[23] ? 24'(-r_yp) : r_yp};
                                r_mb    <= {16'd0, r_vx[15] ? 16'(-r_vx) : r_vx};
                                r_phase <= P_P2;
                            end
                            P_P2: begin
                                // Turn rate carries the sign opposite to the sum.
                                r_neg   <= (n_sum > 48'sd0);
                                r_ma    <= {32'd0, n_mag};
                                r_mb    <= r_tr_gain;
                                r_phase <= P_R;
                            end
                            P_R: begin
                                r_ma    <= {48'd0, n_r};
                                r_mb    <= {16'd0, r_airspeed};
                                r_phase <= P_RV;
                            end
                            P_RV: begin
                                r_cx    <= GRAV_Q24;
                                r_cy    <= $signed({3'd0, r_acc[46:0]});
                                r_cz    <= '0;
                                r_i     <= '0;
                                r_state <= S_CORD;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_CORD: begin
                    if (r_i == 6'(LP_STEPS)) begin
                        r_res_bank <= n_bank[14:0];
                        r_res_rev  <= 1'b0;
                        r_state    <= S_OUT;
                    end else begin
                        if (!r_cy[49]) begin
                            r_cx <= r_cx + n_dx;
                            r_cy <= r_cy - n_dy;
                            r_cz <= r_cz + $signed({4'd0, atan_q30(r_i[4:0])});
                        end else begin
                            r_cx <= r_cx - n_dx;
                            r_cy <= r_cy + n_dy;
                            r_cz <= r_cz - $signed({4'd0, atan_q30(r_i[4:0])});
                        end
                        r_i <= r_i + 6'd1;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_bank  <= r_res_bank;
                        r_out_rev   <= r_res_rev;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### hdl/ltbc_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ltbc_checker
// Port-level checks on the lateral track controller, bound to the core module.
// ---------------------------------------------------------------------------
`include "lateral_track_bank_control_core_assert.svh"

module ltbc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        i_command,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [14:0] o_bank_command
);
    // A tracking word leaves the core busy in the cycle after it is taken.
    `LTBC_ASSERT_NEXT(a_busy_after_step, i_in_valid && o_in_ready && i_command, !o_in_ready, "core ready right after a tracking word")
    // An airspeed update taken while idle and empty gives no result.
    `LTBC_ASSERT_NEXT(a_update_silent, i_in_valid && o_in_ready && !i_command && !o_out_valid, !o_out_valid, "result after an airspeed update")
    `LTBC_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid, "result dropped while stalled")
    `LTBC_ASSERT_NEXT(a_out_stable, o_out_valid && !i_out_ready, $stable(o_bank_command), "result changed while stalled")
endmodule

bind lateral_track_bank_control_core ltbc_checker u_ltbc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .i_command      (i_command),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_bank_command (o_bank_command)
);

### tb/tb_lateral_track_bank_control_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_lateral_track_bank_control_core
// Drives airspeed updates and tracking steps into the lateral track bank
// controller, predicts each bank command in fixed point, and compares every
// result word against the oldest prediction.
// ---------------------------------------------------------------------------
import ltbc_pkg::*;

typedef struct packed {
    logic [14:0] bank;
    logic        rev;
} bank_word_t;

class bank_scoreboard;
    bank_word_t   pending[$];
    int           errors;
    logic [13:0]  bank_limit;
    logic [31:0]  la_gain;
    logic [31:0]  tr_gain;
    logic         enable;
    logic signed [15:0] airspeed;

    function void reset_state();
        pending.delete();
        errors     = 0;
        bank_limit = BANK_LIMIT_RST;
        la_gain    = LA_GAIN_RST;
        tr_gain    = TR_GAIN_RST;
        enable     = 1'b0;
        airspeed   = '0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] data);
        case (idx)
            REG_BANK_LIMIT: bank_limit = data[13:0];
            REG_LA_GAIN:    la_gain    = data;
            REG_TR_GAIN:    tr_gain    = data;
            REG_ENABLE:     enable     = data[0];
            default: ;
        endcase
    endfunction

    static function longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    // Angle of (gravity, y) in Q2.30 by CORDIC vectoring.
    static function longint vector_angle(longint yin);
        longint x, y, z, dx, dy;
        x = 164528285;
        y = yin;
        z = 0;
        for (int i = 0; i < 16 && i < TABLE_LEN; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (y >= 0) begin
                x += dx; y -= dy; z += longint'(atan_q30(i[4:0]));
            end else begin
                x -= dx; y += dy; z -= longint'(atan_q30(i[4:0]));
            end
        end
        return z;
    endfunction

    function void note_input(logic cmd, logic [15:0] asp, logic signed [15:0] vx,
                             logic signed [15:0] vy, logic signed [23:0] yp);
        longint v, avy, mb, bank, sum, ang;
        longint unsigned vsq, xla, mag, r;
        logic [127:0] wide;
        bank_word_t w;
        if (!cmd) begin
            airspeed = asp;
            return;
        end
        if (!enable || airspeed <= 0) return;
        v   = airspeed;
        mb  = bank_limit;
        avy = (vy < 0) ? -longint'(vy) : longint'(vy);
        if (avy <= -longint'(vx)) begin
            bank = (vy < 0) ? mb : -mb;
            w.bank = bank[14:0];
            w.rev  = 1'b1;
            pending.push_back(w);
            return;
        end
        vsq  = v * v;
        wide = 128'(la_gain) * 128'(vsq);
        xla  = wide[95:32];
        sum  = longint'(xla) * vy + longint'(yp) * vx;
        mag  = (sum < 0) ? -sum : sum;
        r    = 64'(tr_gain) * (mag >> 24) + ((64'(tr_gain) * (mag & 64'hFFFFFF)) >> 24);
        if (r > 64'hFFFFFFFF) r = 64'hFFFFFFFF;
        ang  = vector_angle(longint'(r * longint'(v)));
        bank = floor_shift(ang + 32768, 16);
        if (sum > 0) bank = -bank;
        if (bank > mb) bank = mb;
        if (bank < -mb) bank = -mb;
        w.bank = bank[14:0];
        w.rev  = 1'b0;
        pending.push_back(w);
    endfunction

    function void check_result(logic [14:0] bank, logic rev);
        bank_word_t e;
        if (pending.size() == 0) begin
            $error("unexpected result word bank=%0d reversed=%0d", $signed(bank), rev);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (e.bank !== bank) begin
            $error("bank_command expected %0d actual %0d", $signed(e.bank), $signed(bank));
            errors++;
        end
        if (e.rev !== rev) begin
            $error("reversed expected %0d actual %0d", e.rev, rev);
            errors++;
        end
    endfunction
endclass

module tb_lateral_track_bank_control_core;
    localparam int STALL_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_command = 1'b0;
    logic [15:0] i_airspeed = '0;
    logic [15:0] i_track_vel_x = '0;
    logic [15:0] i_track_vel_y = '0;
    logic [23:0] i_cross_track_pos = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [14:0] o_bank_command;
    logic        o_reversed;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    bank_scoreboard sb;
    bit          calm = 1'b0;
    bit          hold_off = 1'b0;
    int          idle_cycles = 0;
    int          out_idle = 0;

    lateral_track_bank_control_core DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Result side: checks and random back-pressure in short bursts.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_bank_command, o_reversed);
        if (out_idle > 0) begin
            out_idle    <= out_idle - 1;
            i_out_ready <= 1'b0;
        end else if (hold_off) begin
            i_out_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 3) == 0) begin
            out_idle    <= $urandom_range(0, 5);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("lateral_track_bank_control_core: mismatch");
            $finish;
        end
    end

    task automatic write_cfg(logic [1:0] idx, logic [31:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.write_reg(idx, data);
        @(posedge i_clk);
    endtask

    // Valid stays high after acceptance so that words can follow back to back;
    // it drops at the start of a gap or of a drain.
    task automatic send_word(logic cmd, logic [15:0] asp, logic [15:0] vx,
                             logic [15:0] vy, logic [23:0] yp);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 6);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_command         <= cmd;
        i_airspeed        <= asp;
        i_track_vel_x     <= vx;
        i_track_vel_y     <= vy;
        i_cross_track_pos <= yp;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_input(cmd, asp, vx, vy, yp);
    endtask

    // Lets the pipeline drain before touching registers.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic random_step();
        logic [15:0] vx, vy, asp;
        logic [23:0] yp;
        int pick;
        pick = $urandom_range(0, 9);
        vx  = $urandom;
        vy  = $urandom;
        yp  = $urandom;
        asp = $urandom;
        if (pick == 0) begin
            send_word(1'b0, asp, vx, vy, yp);
        end else if (pick == 1) begin
            send_word(1'b0, 16'($urandom_range(1, 16000)), vx, vy, yp);
        end else begin
            // Mostly small, realistic values so the normal branch is reached.
            if (pick < 7) begin
                vx = 16'($signed($urandom_range(0, 8000)) - 1000);
                vy = 16'($signed($urandom_range(0, 4000)) - 2000);
                yp = 24'($signed($urandom_range(0, 200000)) - 100000);
            end
            send_word(1'b1, asp, vx, vy, yp);
        end
    endtask

    initial begin
        sb = new();
        sb.reset_state();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Disabled controller and non-positive airspeed give no result.
        send_word(1'b0, 16'd5120, 16'd5000, 16'd100, 24'd1000);
        send_word(1'b1, 16'd0, 16'd5000, 16'd100, 24'd1000);
        drain();
        write_cfg(REG_ENABLE, 32'd1);
        send_word(1'b0, 16'h0000, 16'd0, 16'd0, 24'd0);
        send_word(1'b1, 16'd0, 16'd5000, 16'd100, 24'd1000);
        send_word(1'b0, 16'h8000, 16'd0, 16'd0, 24'd0);
        send_word(1'b1, 16'd0, 16'd5000, 16'd100, 24'd1000);
        send_word(1'b0, 16'h7FFF, 16'd0, 16'd0, 24'd0);
        // Heading away, including a standstill, both signs of vy.
        send_word(1'b1, 16'd0, 16'd0, 16'd0, 24'd0);
        send_word(1'b1, 16'd0, 16'h8000, 16'h7FFF, 24'h7FFFFF);
        send_word(1'b1, 16'd0, 16'h8000, 16'h8000, 24'h800000);
        send_word(1'b1, 16'd0, -16'sd300, 16'd300, 24'd0);
        // Normal branch at field extremes and with saturation.
        send_word(1'b1, 16'd0, 16'h7FFF, 16'h7FFF, 24'h7FFFFF);
        send_word(1'b1, 16'd0, 16'h7FFF, 16'h8000, 24'h800000);
        send_word(1'b1, 16'd0, 16'd5000, 16'd0, 24'd0);
        send_word(1'b1, 16'd0, 16'd1, 16'd0, 24'h000100);
        send_word(1'b0, 16'd5120, 16'd0, 16'd0, 24'd0);
        send_word(1'b1, 16'd0, 16'd5000, -16'sd200, 24'd25600);
        send_word(1'b1, 16'd0, 16'd5000, 16'd200, -24'sd25600);
        drain();

        // Long hold-off on the result side while words keep coming.
        hold_off = 1'b1;
        fork
            begin
                repeat (600) @(posedge i_clk);
                hold_off = 1'b0;
            end
            repeat (10) random_step();
        join
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    write_cfg(REG_BANK_LIMIT, 32'd12868);
                    write_cfg(REG_LA_GAIN, 32'hFFFFFFFF);
                    write_cfg(REG_TR_GAIN, 32'hFFFFFFFF);
                end
                1: begin
                    write_cfg(REG_BANK_LIMIT, 32'd1430);
                    write_cfg(REG_LA_GAIN, 32'd0);
                    write_cfg(REG_TR_GAIN, 32'd0);
                end
                2: begin
                    write_cfg(REG_BANK_LIMIT, 32'h3FFF);
                    write_cfg(REG_LA_GAIN, $urandom);
                    write_cfg(REG_TR_GAIN, 32'($urandom_range(0, 2000000)));
                end
                3: write_cfg(REG_ENABLE, 32'd0);
                4: begin
                    write_cfg(REG_ENABLE, 32'd1);
                    write_cfg(REG_BANK_LIMIT, 32'd8579);
                    write_cfg(REG_LA_GAIN, 32'd2963192);
                    write_cfg(REG_TR_GAIN, 32'd83886);
                end
                default: begin
                    write_cfg(REG_TR_GAIN, 32'($urandom_range(0, 400000)));
                    calm = 1'b1;
                end
            endcase
            repeat (phase == 3 ? 20 : 80) random_step();
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("lateral_track_bank_control_core: match");
        end else begin
            $display("lateral_track_bank_control_core: mismatch");
        end
        $finish;
    end
endmodule

### files.f
+incdir+hdl
hdl/ltbc_pkg.sv
hdl/lateral_track_bank_control_core.sv
hdl/ltbc_checker.sv
tb/tb_lateral_track_bank_control_core.sv
